// ===== rtl/core/dqs_pkg.sv =====
// ----------------------------------------------------------------------------
// dqs_pkg
// Operation codes, result status codes and the result word type shared by
// the double-ended queue with search and dump.
// ----------------------------------------------------------------------------
package dqs_pkg;

   localparam int OP_WIDTH     = 3;
   localparam int STATUS_WIDTH = 3;
   localparam int VALUE_WIDTH  = 32;

   localparam logic [OP_WIDTH-1:0] OP_INSERT_HEAD = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_INSERT_TAIL = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_REMOVE_HEAD = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_REMOVE_TAIL = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_SEARCH      = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_DUMP        = 3'd5;

   localparam logic [STATUS_WIDTH-1:0] ST_ELEMENT   = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FOUND     = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW  = 3'd4;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [VALUE_WIDTH-1:0]  element;
      logic                    last;
   } rsp_word_type;

endpackage

// ===== rtl/core/deque_with_search_and_dump.sv =====
// ----------------------------------------------------------------------------
// deque_with_search_and_dump
// Double-ended queue of signed values in a ring buffer, with membership
// search and a dump of every element from head to tail.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid req_stall req_op req_value    | in
//   result  | rsp_valid rsp_stall rsp_status          | out
//           | rsp_element rsp_last                    |
//
// A search or dump walks the live slots through the single read port of the
// slot store, one slot a cycle unless a dump waits on a stalled result.
// Requests stall until a search, dump, overflow or empty result is out.
// Reset clears the head index and the entry count at once; the slot store
// needs no clearing. A stalled result word holds in the output register,
// and a dump pauses its slot reads until the word is taken.
// ----------------------------------------------------------------------------
module deque_with_search_and_dump #(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [dqs_pkg::OP_WIDTH-1:0]           req_op,
   input  logic signed [dqs_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [dqs_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic signed [dqs_pkg::VALUE_WIDTH-1:0] rsp_element,
   output logic                                   rsp_last
);

   localparam int AW = $clog2(DEPTH);

   logic                    out_free;
   logic                    out_load;
   dqs_pkg::rsp_word_type   out_word;
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [DATA_WIDTH-1:0]   ram_wr_data;
   logic                    ram_rd_en;
   logic [AW-1:0]           ram_rd_addr;
   logic [DATA_WIDTH-1:0]   ram_rd_data;

   logic                    rsp_valid_ff, rsp_valid_in;
   dqs_pkg::rsp_word_type   rsp_word_ff, rsp_word_in;

   dqs_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_op      (req_op),
      .req_value   (req_value),
      .req_stall   (req_stall),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_word    (out_word),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   dqs_slot_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_free) begin
         rsp_valid_in = out_load;
         rsp_word_in  = out_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_word_ff.status;
   assign rsp_element = rsp_word_ff.element;
   assign rsp_last    = rsp_word_ff.last;

endmodule

// ===== rtl/core/dqs_slot_ram.sv =====
// ----------------------------------------------------------------------------
// dqs_slot_ram
// Slot store of the ring buffer: one write port and one read port, with the
// read data registered and held until the next read.
// ----------------------------------------------------------------------------
module dqs_slot_ram #(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqs_ctrl
// Sequencer of the queue: keeps the head index and the entry count, writes
// inserted values into the slot store, and walks the live slots one read a
// cycle for search and dump, a dump pausing while its result is stalled.
// ----------------------------------------------------------------------------
module dqs_ctrl #(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [dqs_pkg::OP_WIDTH-1:0]        req_op,
   input  logic signed [dqs_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                req_stall,
   input  logic                                out_free,
   output logic                                out_load,
   output dqs_pkg::rsp_word_type               out_word,
   output logic                                ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]            ram_wr_addr,
   output logic [DATA_WIDTH-1:0]               ram_wr_data,
   output logic                                ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]            ram_rd_addr,
   input  logic [DATA_WIDTH-1:0]               ram_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ONE  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic [AW-1:0]                     head_ff, head_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     rd_ptr_ff, rd_ptr_in;
   logic                              rv_ff, rv_in;
   logic                              rl_ff, rl_in;
   logic                              hit_ff, hit_in;
   logic                              dump_ff, dump_in;
   logic [DATA_WIDTH-1:0]             val_ff, val_in;
   logic [dqs_pkg::STATUS_WIDTH-1:0]  pend_ff, pend_in;

   logic [63:0]    value64;
   logic [63:0]    wide;
   logic [AW-1:0]  pos_off;
   logic [SW-1:0]  pos_sum;
   logic [AW-1:0]  ring_pos;
   logic [AW-1:0]  head_dec;
   logic [AW-1:0]  head_inc;
   logic           full;
   logic           empty;
   logic           match;
   logic           consume;
   logic           issue;

   assign value64 = {32'b0, req_value};
   assign wide    = 64'(signed'(ram_rd_data));
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign match   = (ram_rd_data == val_ff);

   assign pos_off  = (state_ff == S_IDLE) ? count_ff[AW-1:0] : rd_ptr_ff[AW-1:0];
   assign pos_sum  = {1'b0, head_ff} + {1'b0, pos_off};
   assign ring_pos = (pos_sum >= SW'(DEPTH)) ? AW'(pos_sum - SW'(DEPTH)) : pos_sum[AW-1:0];
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : AW'(head_ff - 1'b1);
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : AW'(head_ff + 1'b1);

   assign req_stall = (state_ff != S_IDLE);
   assign consume   = rv_ff && (!dump_ff || out_free);
   assign issue     = (state_ff == S_SCAN) && (rd_ptr_ff != count_ff) && (!rv_ff || consume);

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      rv_in       = rv_ff;
      rl_in       = rl_ff;
      hit_in      = hit_ff;
      dump_in     = dump_ff;
      val_in      = val_ff;
      pend_in     = pend_ff;
      out_load    = 1'b0;
      out_word    = '{status: pend_ff, element: '0, last: 1'b1};
      ram_wr_en   = 1'b0;
      ram_wr_addr = ring_pos;
      ram_wr_data = value64[DATA_WIDTH-1:0];
      ram_rd_en   = 1'b0;
      ram_rd_addr = ring_pos;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  dqs_pkg::OP_INSERT_HEAD, dqs_pkg::OP_INSERT_TAIL: begin
                     if (full) begin
                        pend_in  = dqs_pkg::ST_OVERFLOW;
                        state_in = S_ONE;
                     end else begin
                        ram_wr_en = 1'b1;
                        if (req_op == dqs_pkg::OP_INSERT_HEAD) begin
                           ram_wr_addr = head_dec;
                           head_in     = head_dec;
                        end
                        count_in = CW'(count_ff + 1'b1);
                     end
                  end
                  dqs_pkg::OP_REMOVE_HEAD: begin
                     if (!empty) begin
                        head_in  = head_inc;
                        count_in = CW'(count_ff - 1'b1);
                     end
                  end
                  dqs_pkg::OP_REMOVE_TAIL: begin
                     if (!empty) begin
                        count_in = CW'(count_ff - 1'b1);
                     end
                  end
                  dqs_pkg::OP_SEARCH, dqs_pkg::OP_DUMP: begin
                     if (empty) begin
                        pend_in  = dqs_pkg::ST_EMPTY;
                        state_in = S_ONE;
                     end else begin
                        state_in  = S_SCAN;
                        dump_in   = (req_op == dqs_pkg::OP_DUMP);
                        rd_ptr_in = '0;
                        rv_in     = 1'b0;
                        hit_in    = 1'b0;
                        val_in    = value64[DATA_WIDTH-1:0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (consume) begin
               rv_in = 1'b0;
               if (dump_ff) begin
                  out_load = 1'b1;
                  out_word = '{status: dqs_pkg::ST_ELEMENT, element: wide[31:0], last: rl_ff};
                  if (rl_ff) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  hit_in = hit_ff | match;
                  if (rl_ff) begin
                     pend_in  = (hit_ff | match) ? dqs_pkg::ST_FOUND : dqs_pkg::ST_NOT_FOUND;
                     state_in = S_ONE;
                  end
               end
            end
            if (issue) begin
               ram_rd_en = 1'b1;
               rv_in     = 1'b1;
               rd_ptr_in = CW'(rd_ptr_ff + 1'b1);
               rl_in     = (CW'(rd_ptr_ff + 1'b1) == count_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         rd_ptr_ff <= '0;
         rv_ff     <= 1'b0;
         rl_ff     <= 1'b0;
         hit_ff    <= 1'b0;
         dump_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         rv_ff     <= rv_in;
         rl_ff     <= rl_in;
         hit_ff    <= hit_in;
         dump_ff   <= dump_in;
      end
      val_ff  <= val_in;
      pend_ff <= pend_in;
   end

endmodule
